FILE: rtl/aprq_pkg.sv
// Shared constants and types of the adaptable priority queue.
package aprq_pkg;

	// Default size of the queue and default stored key width.
	localparam int DEPTH_DEF     = 16;
	localparam int KEY_WIDTH_DEF = 32;

	// Fixed field widths of the stream items.
	localparam int FUNC_W    = 3;
	localparam int DATA_W    = 32;
	localparam int HANDLE_W  = 4;
	localparam int COUNT_W   = 5;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 80;

	// Operation codes carried in the input tuser.
	localparam logic [FUNC_W-1:0] OP_INSERT  = 3'd0;
	localparam logic [FUNC_W-1:0] OP_REM_MIN = 3'd1;
	localparam logic [FUNC_W-1:0] OP_REM_HND = 3'd2;
	localparam logic [FUNC_W-1:0] OP_REPLACE = 3'd3;
	localparam logic [FUNC_W-1:0] OP_PEEK    = 3'd4;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_BADH  = 2'd3
	} status_t;

endpackage

FILE: rtl/adaptable_priority_queue.sv
// Adaptable priority queue kept as a sorted list in a memory with one read and one write port.
//
//  Channel | Direction | Fields (low bit first)                        | Handshake
//  --------+-----------+-----------------------------------------------+---------------
//  s_      | in        | tuser: func; tdata: key, payload, handle      | s_tvalid/ready
//  m_      | out       | tdata: status, new_handle, min_valid,         | m_tvalid/ready
//          |           |        min_key, min_payload, count            |
//
// Sequencing: each operation is run by a small sequencer around one memory
// read port, one write port and one signed key comparator. Peek and every
// error case read the minimum and then load the result register. A removal
// walks the list, taking every held entry in turn (read, then compare and
// move back by one). An insert first searches for the lowest free handle at
// one handle a cycle, then shifts larger entries up, one read and one write
// per entry moved. A replace is a removal followed by an insert.
// Reset clears the count, the handle-in-use bits and the result register at
// once; the entry memory is not cleared, as only entries below the count are
// ever used. The block takes a new item only when the sequencer is idle; a
// finished result waits in the output register, and the sequencer stalls in
// its last state only if an earlier result has still not been taken.
module adaptable_priority_queue
	import aprq_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// key [31:0], payload [63:32], handle [67:64], zero fill [71:68]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// func [2:0]
	input  logic [FUNC_W-1:0]    s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// status [1:0], new_handle [5:2], min_valid [6], min_key [38:7],
	// min_payload [70:39], count [75:71], zero fill [79:76]
	output logic [M_TDATA_W-1:0] m_tdata
);

	// Width of a handle or an entry address, and of a count up to DEPTH.
	localparam int HW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [KEY_WIDTH-1:0] key;
		logic [DATA_W-1:0]    payload;
		logic [HW-1:0]        hnd;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RM_RD,
		S_RM_PROC,
		S_HFIND,
		S_INS_RD,
		S_INS_PROC,
		S_MIN_RD,
		S_FIN
	} state_t;

	state_t               state_q;
	logic [FUNC_W-1:0]    op_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [DATA_W-1:0]    pay_q;
	logic [HW-1:0]        hidx_q;
	logic [HW-1:0]        nh_q;
	logic [HW-1:0]        hcnt_q;
	status_t              status_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        j_q;
	logic [CW-1:0]        i_q;
	logic                 found_q;
	logic [DEPTH-1:0]     in_use_q;

	// Result register.
	logic                 m_tvalid_q;
	status_t              out_status_q;
	logic [HANDLE_W-1:0]  out_nh_q;
	logic                 out_minv_q;
	logic [DATA_W-1:0]    out_mink_q;
	logic [DATA_W-1:0]    out_minp_q;
	logic [COUNT_W-1:0]   out_cnt_q;

	// Entry memory with a registered read port.
	entry_t               mem_q [DEPTH];
	entry_t               rd_q;
	logic                 we;
	logic [HW-1:0]        waddr;
	logic [HW-1:0]        raddr;
	entry_t               wdata;

	// Input decode.
	logic [DATA_W-1:0]    key_in;
	logic [63:0]          key_sx;
	logic [KEY_WIDTH-1:0] key_conv;
	logic [8:0]           h_ext;
	logic [HW-1:0]        h_idx;
	logic                 h_valid;
	logic                 accept;

	// Loop helpers.
	logic [CW-1:0]        j_m1;
	logic [CW-1:0]        i_m1;
	logic [CW-1:0]        count_m1;
	logic                 rm_match;
	logic                 ins_greater;
	entry_t               new_entry;
	logic [63:0]          min_key_ext;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// The 32-bit key is sign-extended, then kept at the stored key width.
	assign key_in   = s_tdata[31:0];
	assign key_sx   = {{32{key_in[31]}}, key_in};
	assign key_conv = key_sx[KEY_WIDTH-1:0];
	assign h_ext    = 9'(s_tdata[67:64]);
	assign h_idx    = h_ext[HW-1:0];
	assign h_valid  = (h_ext < 9'(DEPTH)) && in_use_q[h_idx];

	assign j_m1      = CW'(j_q - 1'b1);
	assign i_m1      = CW'(i_q - 1'b1);
	assign count_m1  = CW'(count_q - 1'b1);
	assign rm_match  = (op_q == OP_REM_MIN) ? (j_q == '0) : (rd_q.hnd == hidx_q);
	// Equal keys stop the shift, so a new entry lands behind its equals.
	assign ins_greater = $signed(rd_q.key) > $signed(key_q);
	assign new_entry   = '{key: key_q, payload: pay_q, hnd: nh_q};
	// A stored key narrower than 32 bits reads back zero-extended.
	assign min_key_ext = 64'(rd_q.key);

	// Memory port control.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = new_entry;
		raddr = '0;
		unique case (state_q)
			S_RM_RD: begin
				raddr = j_q[HW-1:0];
			end
			S_RM_PROC: begin
				// Every entry behind the removed one moves down by one place.
				we    = found_q;
				waddr = j_m1[HW-1:0];
				wdata = rd_q;
			end
			S_INS_RD: begin
				raddr = i_m1[HW-1:0];
				if (i_q == '0) begin
					we    = 1'b1;
					waddr = '0;
				end
			end
			S_INS_PROC: begin
				we    = 1'b1;
				waddr = i_q[HW-1:0];
				wdata = ins_greater ? rd_q : new_entry;
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_PEEK;
			key_q        <= '0;
			pay_q        <= '0;
			hidx_q       <= '0;
			nh_q         <= '0;
			hcnt_q       <= '0;
			status_q     <= ST_OK;
			count_q      <= '0;
			j_q          <= '0;
			i_q          <= '0;
			found_q      <= 1'b0;
			in_use_q     <= '0;
			m_tvalid_q   <= 1'b0;
			out_status_q <= ST_OK;
			out_nh_q     <= '0;
			out_minv_q   <= 1'b0;
			out_mink_q   <= '0;
			out_minp_q   <= '0;
			out_cnt_q    <= '0;
		end else begin
			// In the final state a taken result is replaced by the new one there.
			if (m_tvalid_q && m_tready && state_q != S_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= s_tuser;
						key_q    <= key_conv;
						pay_q    <= s_tdata[63:32];
						hidx_q   <= h_idx;
						nh_q     <= '0;
						hcnt_q   <= '0;
						j_q      <= '0;
						found_q  <= 1'b0;
						status_q <= ST_OK;
						priority if (count_q == '0 && s_tuser != OP_INSERT) begin
							status_q <= ST_EMPTY;
							state_q  <= S_MIN_RD;
						end else if (s_tuser == OP_INSERT) begin
							if (count_q == CW'(DEPTH)) begin
								status_q <= ST_FULL;
								state_q  <= S_MIN_RD;
							end else begin
								state_q <= S_HFIND;
							end
						end else if (s_tuser == OP_REM_MIN) begin
							state_q <= S_RM_RD;
						end else if (s_tuser == OP_REM_HND || s_tuser == OP_REPLACE) begin
							if (h_valid) begin
								state_q <= S_RM_RD;
							end else begin
								status_q <= ST_BADH;
								state_q  <= S_MIN_RD;
							end
						end else begin
							// Peek and the unused codes only report.
							state_q <= S_MIN_RD;
						end
					end
				end
				S_RM_RD: begin
					state_q <= S_RM_PROC;
				end
				S_RM_PROC: begin
					if (!found_q && rm_match) begin
						found_q            <= 1'b1;
						in_use_q[rd_q.hnd] <= 1'b0;
					end
					if (j_q == count_m1) begin
						count_q <= count_m1;
						hcnt_q  <= '0;
						state_q <= (op_q == OP_REPLACE) ? S_HFIND : S_MIN_RD;
					end else begin
						j_q     <= CW'(j_q + 1'b1);
						state_q <= S_RM_RD;
					end
				end
				S_HFIND: begin
					// Lowest free handle, one handle per cycle.
					if (!in_use_q[hcnt_q]) begin
						nh_q             <= hcnt_q;
						in_use_q[hcnt_q] <= 1'b1;
						i_q              <= count_q;
						state_q          <= S_INS_RD;
					end else begin
						hcnt_q <= HW'(hcnt_q + 1'b1);
					end
				end
				S_INS_RD: begin
					if (i_q == '0) begin
						count_q <= CW'(count_q + 1'b1);
						state_q <= S_MIN_RD;
					end else begin
						state_q <= S_INS_PROC;
					end
				end
				S_INS_PROC: begin
					if (ins_greater) begin
						i_q     <= i_m1;
						state_q <= S_INS_RD;
					end else begin
						count_q <= CW'(count_q + 1'b1);
						state_q <= S_MIN_RD;
					end
				end
				S_MIN_RD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= status_q;
						out_nh_q     <= HANDLE_W'(nh_q);
						out_cnt_q    <= COUNT_W'(count_q);
						if (count_q != '0) begin
							out_minv_q <= 1'b1;
							out_mink_q <= min_key_ext[DATA_W-1:0];
							out_minp_q <= rd_q.payload;
						end else begin
							out_minv_q <= 1'b0;
							out_mink_q <= '0;
							out_minp_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, out_cnt_q, out_minp_q, out_mink_q, out_minv_q, out_nh_q,
		out_status_q};

	// The count never goes beyond the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// Between operations every held entry owns exactly one handle.
	a_handles_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(in_use_q) == 32'(count_q)))
		else $error("handles in use differ from entry count");

	// The free handle search only runs when a free handle exists.
	a_hfind_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HFIND) |-> ($countones(in_use_q) < DEPTH))
		else $error("handle search with no free handle");

	// An insert lands at or below the current count.
	a_ins_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_PROC || state_q == S_INS_RD) |-> (i_q <= count_q))
		else $error("insert position beyond count");

endmodule

FILE: sim/adaptable_priority_queue_test.sv
// Self-checking testbench of the adaptable priority queue with a cycle-free queue predictor.
`timescale 1ns / 100ps

module adaptable_priority_queue_test;
	import aprq_pkg::*;

	localparam int QDEPTH       = DEPTH_DEF;
	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 7;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 200;
	localparam int TIMEOUT_NS   = 8_000_000;
	localparam int PLAN_ROWS    = 20;
	localparam int RAND_ITEMS   = 1868;
	localparam int PHASE_LEN    = RAND_ITEMS / 4;
	localparam int MAX_REPORTS  = 10;

	// Function codes above peek behave as peek.
	localparam logic [FUNC_W-1:0] OP_UNUSED_LO = 3'd5;
	localparam logic [FUNC_W-1:0] OP_UNUSED_HI = 3'd7;

	localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFFFFFF;
	localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh80000000;

	typedef struct packed {
		logic [FUNC_W-1:0]          func;
		logic signed [DATA_W-1:0]   key;
		logic signed [DATA_W-1:0]   payload;
		logic [HANDLE_W-1:0]        handle;
	} item_t;

	typedef struct packed {
		status_t                    status;
		logic [HANDLE_W-1:0]        new_handle;
		logic                       min_valid;
		logic signed [DATA_W-1:0]   min_key;
		logic signed [DATA_W-1:0]   min_payload;
		logic [COUNT_W-1:0]         count;
	} result_t;

	// One row of the directed plan: the item, how often it is sent, and a
	// hand-written result where one is given.
	typedef struct packed {
		item_t                      op;
		logic [4:0]                 reps;
		logic                       known;
		result_t                    want;
	} plan_row_t;

	localparam result_t EMPTY_RES = '{ST_EMPTY, 4'd0, 1'b0, 32'sd0, 32'sd0, 5'd0};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [FUNC_W-1:0]    s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	adaptable_priority_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Shadow copy of the sorted list, ascending by key, equal keys in arrival order.
	logic signed [DATA_W-1:0] shadow_key [QDEPTH];
	logic signed [DATA_W-1:0] shadow_pay [QDEPTH];
	logic [HANDLE_W-1:0]      shadow_hnd [QDEPTH];
	logic [QDEPTH-1:0]        shadow_busy = '0;
	int                       shadow_count = 0;

	result_t      pending_results [$];
	int unsigned  bad_results = 0;
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_stall_pct = 0;
	int unsigned  hold_reqs = 0;

	plan_row_t plan_rows [PLAN_ROWS] = '{
		'{'{OP_PEEK, 32'sd0, 32'sd0, 4'd0}, 5'd1, 1'b1, EMPTY_RES},
		'{'{OP_REM_MIN, 32'sd0, 32'sd0, 4'd0}, 5'd1, 1'b1, EMPTY_RES},
		'{'{OP_REM_HND, 32'sd0, 32'sd0, 4'd0}, 5'd1, 1'b1, EMPTY_RES},
		'{'{OP_REPLACE, 32'sh00050000, 32'sd7, 4'd0}, 5'd1, 1'b1, EMPTY_RES},
		'{'{OP_INSERT, KEY_MAX, KEY_MIN, 4'd0}, 5'd1, 1'b1,
			'{ST_OK, 4'd0, 1'b1, KEY_MAX, KEY_MIN, 5'd1}},
		'{'{OP_INSERT, KEY_MIN, KEY_MAX, 4'd0}, 5'd1, 1'b1,
			'{ST_OK, 4'd1, 1'b1, KEY_MIN, KEY_MAX, 5'd2}},
		'{'{OP_INSERT, 32'sd0, 32'sd1, 4'd0}, 5'd1, 1'b1,
			'{ST_OK, 4'd2, 1'b1, KEY_MIN, KEY_MAX, 5'd3}},
		// An equal key goes behind the one already held.
		'{'{OP_INSERT, 32'sd0, 32'sd2, 4'd0}, 5'd1, 1'b0, '0},
		'{'{OP_REM_HND, 32'sd0, 32'sd0, 4'd5}, 5'd1, 1'b1,
			'{ST_BADH, 4'd0, 1'b1, KEY_MIN, KEY_MAX, 5'd4}},
		'{'{OP_REPLACE, 32'sd9, 32'sd9, 4'd15}, 5'd1, 1'b1,
			'{ST_BADH, 4'd0, 1'b1, KEY_MIN, KEY_MAX, 5'd4}},
		'{'{OP_REM_MIN, 32'sd0, 32'sd0, 4'd0}, 5'd1, 1'b0, '0},
		// The freed handle is the lowest free one again.
		'{'{OP_INSERT, -32'sd1, 32'sd3, 4'd0}, 5'd1, 1'b0, '0},
		'{'{OP_REM_HND, 32'sd0, 32'sd0, 4'd2}, 5'd1, 1'b0, '0},
		// Replace frees its own handle first, so it may hand the same one back.
		'{'{OP_REPLACE, KEY_MIN, 32'sh00010000, 4'd0}, 5'd1, 1'b0, '0},
		'{'{OP_UNUSED_LO, 32'sd0, 32'sd0, 4'd0}, 5'd1, 1'b0, '0},
		'{'{OP_UNUSED_HI, 32'sd0, 32'sd0, 4'd0}, 5'd1, 1'b0, '0},
		'{'{OP_INSERT, 32'sh12340000, 32'sh5A5A5A5A, 4'd0}, 5'd13, 1'b0, '0},
		'{'{OP_INSERT, 32'sd0, 32'sd0, 4'd0}, 5'd1, 1'b1,
			'{ST_FULL, 4'd0, 1'b1, KEY_MIN, 32'sh00010000, 5'd16}},
		'{'{OP_REPLACE, KEY_MAX, 32'sh0F0F0F0F, 4'd7}, 5'd1, 1'b0, '0},
		'{'{OP_PEEK, 32'sd0, 32'sd0, 4'd0}, 5'd1, 1'b0, '0}
	};

	function automatic void shadow_remove(input int pos);
		shadow_busy[shadow_hnd[pos]] = 1'b0;
		for (int i = pos; i < shadow_count - 1; i++) begin
			shadow_key[i] = shadow_key[i + 1];
			shadow_pay[i] = shadow_pay[i + 1];
			shadow_hnd[i] = shadow_hnd[i + 1];
		end
		shadow_count--;
	endfunction

	function automatic logic [HANDLE_W-1:0] shadow_insert(input logic signed [DATA_W-1:0] k,
			input logic signed [DATA_W-1:0] p);
		int h;
		int pos;
		h = 0;
		while (h < QDEPTH && shadow_busy[h]) h++;
		pos = 0;
		while (pos < shadow_count && shadow_key[pos] <= k) pos++;
		for (int i = shadow_count; i > pos; i--) begin
			shadow_key[i] = shadow_key[i - 1];
			shadow_pay[i] = shadow_pay[i - 1];
			shadow_hnd[i] = shadow_hnd[i - 1];
		end
		shadow_key[pos] = k;
		shadow_pay[pos] = p;
		shadow_hnd[pos] = HANDLE_W'(h);
		shadow_busy[h] = 1'b1;
		shadow_count++;
		return HANDLE_W'(h);
	endfunction

	// Applies one operation to the shadow list and returns the result it gives.
	function automatic result_t apply_queue_op(input item_t it);
		result_t r;
		int pos;
		r = '{ST_OK, 4'd0, 1'b0, 32'sd0, 32'sd0, 5'd0};
		case (it.func)
			OP_INSERT: begin
				if (shadow_count >= QDEPTH)
					r.status = ST_FULL;
				else
					r.new_handle = shadow_insert(it.key, it.payload);
			end
			OP_REM_MIN: begin
				if (shadow_count == 0)
					r.status = ST_EMPTY;
				else
					shadow_remove(0);
			end
			OP_REM_HND, OP_REPLACE: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else if (!shadow_busy[it.handle]) begin
					r.status = ST_BADH;
				end else begin
					pos = 0;
					while (shadow_hnd[pos] != it.handle) pos++;
					shadow_remove(pos);
					if (it.func == OP_REPLACE)
						r.new_handle = shadow_insert(it.key, it.payload);
				end
			end
			default: begin
				if (shadow_count == 0)
					r.status = ST_EMPTY;
			end
		endcase
		if (shadow_count > 0) begin
			r.min_valid   = 1'b1;
			r.min_key     = shadow_key[0];
			r.min_payload = shadow_pay[0];
		end
		r.count = COUNT_W'(shadow_count);
		return r;
	endfunction

	// Takes the oldest outstanding result off the list.
	function automatic result_t take_expected();
		result_t w;
		w = pending_results[0];
		pending_results.delete(0);
		return w;
	endfunction

	// Offers one item, waits for its acceptance and files the result it must give.
	task automatic offer_item(input item_t it, input logic known, input result_t want);
		result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.func;
		s_tdata  <= {4'd0, it.handle, it.payload, it.key};
		do @(posedge clk); while (!s_tready);
		r = apply_queue_op(it);
		pending_results.push_back(known ? want : r);
	endtask

	initial begin : stimulus
		item_t it;
		int unsigned r;
		int unsigned ins_pct;
		int unsigned min_pct;
		int unsigned hnd_pct;
		bit growing;
		growing = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_rows[i])
			repeat (plan_rows[i].reps)
				offer_item(plan_rows[i].op, plan_rows[i].known, plan_rows[i].want);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % PHASE_LEN == 0) begin
				// Pause the sender until every outstanding result is back.
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
				case (n / PHASE_LEN)
					0: begin
						send_idle_pct = 0;
						recv_stall_pct = 0;
						hold_reqs++;
					end
					1: begin
						send_idle_pct = 66;
						recv_stall_pct = 0;
					end
					2: begin
						send_idle_pct = 0;
						recv_stall_pct = 66;
					end
					default: begin
						send_idle_pct = 6;
						recv_stall_pct = 6;
					end
				endcase
			end

			// Drift between filling and draining so both ends of the list are reached.
			if ($urandom_range(39) == 0)
				growing = !growing;
			ins_pct = growing ? 60 : 10;
			min_pct = growing ? 10 : 40;
			hnd_pct = growing ? 10 : 30;
			r = $urandom_range(99);
			if (r < ins_pct)
				it.func = OP_INSERT;
			else if (r < ins_pct + min_pct)
				it.func = OP_REM_MIN;
			else if (r < ins_pct + min_pct + hnd_pct)
				it.func = OP_REM_HND;
			else if (r < ins_pct + min_pct + hnd_pct + 10)
				it.func = OP_REPLACE;
			else
				it.func = FUNC_W'($urandom_range(OP_UNUSED_HI, OP_PEEK));

			// Small keys make ties common; the extremes and full-range keys follow.
			case ($urandom_range(9))
				0, 1, 2, 3: it.key = (int'($urandom_range(6)) - 3) * 65536;
				4:          it.key = $urandom_range(1) ? KEY_MAX : KEY_MIN;
				default:    it.key = $urandom;
			endcase
			it.payload = $urandom;

			// Mostly a handle that is held; now and then any handle at all.
			if (shadow_count > 0 && $urandom_range(9) < 8)
				it.handle = shadow_hnd[$urandom_range(shadow_count - 1)];
			else
				it.handle = HANDLE_W'($urandom_range(QDEPTH - 1));

			offer_item(it, 1'b0, '0);
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_results == 0 && pending_results.size() == 0)
			$display("[adaptable_priority_queue] OK");
		else
			$display("[adaptable_priority_queue] ERROR");
		$finish;
	end

	initial begin : result_sink
		int unsigned holds_done;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_reqs) begin
				// Long hold-off so that the output fills and the input stalls.
				holds_done++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status      = status_t'(m_tdata[1:0]);
			got.new_handle  = m_tdata[5:2];
			got.min_valid   = m_tdata[6];
			got.min_key     = m_tdata[38:7];
			got.min_payload = m_tdata[70:39];
			got.count       = m_tdata[75:71];
			if (pending_results.size() == 0) begin
				bad_results++;
				if (bad_results <= MAX_REPORTS)
					$display("%0t: result with none outstanding: status %0d count %0d",
						$realtime, got.status, got.count);
			end else begin
				want = take_expected();
				if (got.status !== want.status || got.new_handle !== want.new_handle ||
						got.min_valid !== want.min_valid || got.min_key !== want.min_key ||
						got.min_payload !== want.min_payload || got.count !== want.count) begin
					bad_results++;
					if (bad_results <= MAX_REPORTS) begin
						$display("%0t: result differs", $realtime);
						$display("  got  status %0d handle %0d valid %0b key %h payload %h count %0d",
							got.status, got.new_handle, got.min_valid, got.min_key,
							got.min_payload, got.count);
						$display("  want status %0d handle %0d valid %0b key %h payload %h count %0d",
							want.status, want.new_handle, want.min_valid, want.min_key,
							want.min_payload, want.count);
					end
				end
			end
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("[adaptable_priority_queue] ERROR");
		$finish;
	end

endmodule
